// File: hdl/bapt_pkg.sv
// shared constants, types and cordic table for the bond angle pipeline
// no dependencies
package bapt_pkg;
    localparam int CoordWidth = 24;
    localparam int AngleFracBits = 14;
    localparam int AngleWidth = AngleFracBits + 2;
    localparam int AccFrac = 30;
    localparam int CordicSteps = 31;
    localparam int DiffWidth = CoordWidth + 1;
    localparam int VecWidth = 26;      // signed, magnitude < 2^25
    localparam int CrossWidth = 52;    // products and sums of two
    localparam int DotWidth = 53;
    localparam int QWidth = 32;        // signed, magnitude < 2^31
    localparam int SqWidth = 64;
    localparam int CxWidth = 36;       // cordic x/y with headroom
    localparam int AccWidth = 34;
    localparam logic [AccWidth-1:0] HalfPiQ30 = 34'd1686629713;
    localparam logic [AccWidth-1:0] PiQ30 = 34'd3373259426;

    typedef logic signed [DiffWidth-1:0] diff_t;
    typedef logic signed [VecWidth-1:0] vec_t;
    typedef logic signed [QWidth-1:0] q_t;
    typedef logic signed [CxWidth-1:0] cx_t;
    typedef logic signed [AccWidth-1:0] acc_t;

    function automatic acc_t atan_tab(input int i);
        case (i)
            0: atan_tab = 34'sd843314857;
            1: atan_tab = 34'sd497837829;
            2: atan_tab = 34'sd263043837;
            3: atan_tab = 34'sd133525159;
            4: atan_tab = 34'sd67021687;
            5: atan_tab = 34'sd33543516;
            6: atan_tab = 34'sd16775851;
            7: atan_tab = 34'sd8388437;
            8: atan_tab = 34'sd4194283;
            9: atan_tab = 34'sd2097149;
            default: atan_tab = acc_t'(64'sd1 <<< (AccFrac - i));
        endcase
    endfunction

    // normalize a vector of 25-bit differences so the largest magnitude is in [2^24,2^25)
    function automatic logic [VecWidth*3-1:0] norm_vec(input diff_t d0, input diff_t d1,
                                                      input diff_t d2);
        logic [DiffWidth-1:0] m0, m1, m2, top;
        logic [VecWidth-1:0] r0, r1, r2;
        int sh;
        m0 = d0[DiffWidth-1] ? DiffWidth'(-d0) : d0;
        m1 = d1[DiffWidth-1] ? DiffWidth'(-d1) : d1;
        m2 = d2[DiffWidth-1] ? DiffWidth'(-d2) : d2;
        top = m0 | m1 | m2;
        sh = 0;
        for (int k = 0; k < DiffWidth; k++) if (top[k]) sh = 24 - k;
        if (sh >= 0) begin
            r0 = VecWidth'(m0) << sh; r1 = VecWidth'(m1) << sh; r2 = VecWidth'(m2) << sh;
        end else begin
            r0 = VecWidth'(m0 >> 1); r1 = VecWidth'(m1 >> 1); r2 = VecWidth'(m2 >> 1);
        end
        if (d0[DiffWidth-1]) r0 = -r0;
        if (d1[DiffWidth-1]) r1 = -r1;
        if (d2[DiffWidth-1]) r2 = -r2;
        norm_vec = {r2, r1, r0};
    endfunction
endpackage

// File: hdl/bapt_isqrt.sv
// pipelined integer square root, one result bit per stage
// depends on bapt_pkg
module bapt_isqrt import bapt_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic [SqWidth-1:0] rad,
    output logic [QWidth-1:0]  root
);
    localparam int Steps = SqWidth / 2;
    logic [SqWidth-1:0] rem_reg [Steps-1];
    logic [QWidth-1:0]  res_reg [Steps];

    // restoring square root, one bit each stage
    for (genvar k = 0; k < Steps; k++) begin : g_step
        logic [SqWidth-1:0] rem_in;
        logic [QWidth-1:0]  res_in;
        logic [QWidth-1:0]  trial;
        logic [SqWidth-1:0] sq;
        if (k == 0) begin : g_first
            assign rem_in = rad;
            assign res_in = '0;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign res_in = res_reg[k-1];
        end
        always_comb begin
            trial = res_in | (QWidth'(1) << (Steps - 1 - k));
            sq = SqWidth'(trial) * SqWidth'(trial);
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                res_reg[k] <= (sq <= rem_in) ? trial : res_in;
            end
        end
        // radicand travels along, not needed after the last stage
        if (k < Steps - 1) begin : g_pass
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= rem_in;
                end
            end
        end
    end
    assign root = res_reg[Steps-1];
endmodule

// File: hdl/bond_angle_three_points.sv
// bond angle at a vertex from three points, streaming pipeline
// throughput one item per cycle while the pipe advances, not during an output stall
// the whole pipe advances when the output register is empty or taken
// reset: aresetn synchronous active low clears all valid bits; data registers hold
// depends on bapt_pkg and bapt_isqrt
module bond_angle_three_points import bapt_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0
    input  logic [215:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // angle_rad [15:0]
    output logic [15:0]  m_tdata,
    // degenerate
    output logic         m_tuser
);
    localparam int SqLat = SqWidth / 2;
    localparam int Lat = 5 + SqLat + 1 + CordicSteps;
    logic en;
    logic [Lat:0] vld_reg;
    logic [Lat:0] dg_reg;
    assign en = !m_tvalid || m_tready;
    assign s_tready = en && aresetn;

    // stage 1: differences and normalization
    diff_t u0, u1, u2, w0, w1, w2;
    always_comb begin
        u0 = diff_t'($signed(s_tdata[23:0]))    - diff_t'($signed(s_tdata[167:144]));
        u1 = diff_t'($signed(s_tdata[47:24]))   - diff_t'($signed(s_tdata[191:168]));
        u2 = diff_t'($signed(s_tdata[71:48]))   - diff_t'($signed(s_tdata[215:192]));
        w0 = diff_t'($signed(s_tdata[95:72]))   - diff_t'($signed(s_tdata[167:144]));
        w1 = diff_t'($signed(s_tdata[119:96]))  - diff_t'($signed(s_tdata[191:168]));
        w2 = diff_t'($signed(s_tdata[143:120])) - diff_t'($signed(s_tdata[215:192]));
    end
    vec_t u_reg [3], w_reg [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            {u_reg[2], u_reg[1], u_reg[0]} <= norm_vec(u0, u1, u2);
            {w_reg[2], w_reg[1], w_reg[0]} <= norm_vec(w0, w1, w2);
        end
    end

    // stage 2: products
    logic signed [CrossWidth-1:0] p_reg [9];
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= u_reg[1] * w_reg[2]; p_reg[1] <= u_reg[2] * w_reg[1];
            p_reg[2] <= u_reg[2] * w_reg[0]; p_reg[3] <= u_reg[0] * w_reg[2];
            p_reg[4] <= u_reg[0] * w_reg[1]; p_reg[5] <= u_reg[1] * w_reg[0];
            p_reg[6] <= u_reg[0] * w_reg[0]; p_reg[7] <= u_reg[1] * w_reg[1];
            p_reg[8] <= u_reg[2] * w_reg[2];
        end
    end

    // stage 3: cross and dot sums
    logic signed [DotWidth-1:0] c_reg [4];
    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg[0] <= DotWidth'(p_reg[0]) - DotWidth'(p_reg[1]);
            c_reg[1] <= DotWidth'(p_reg[2]) - DotWidth'(p_reg[3]);
            c_reg[2] <= DotWidth'(p_reg[4]) - DotWidth'(p_reg[5]);
            c_reg[3] <= DotWidth'(p_reg[6]) + DotWidth'(p_reg[7]) + DotWidth'(p_reg[8]);
        end
    end

    // stage 4: common shift of the four magnitudes below 2^31
    logic [DotWidth-1:0] mg [4];
    logic [DotWidth-1:0] top;
    int sh;
    q_t q_next [4];
    always_comb begin
        top = '0;
        for (int k = 0; k < 4; k++) begin
            mg[k] = c_reg[k][DotWidth-1] ? DotWidth'(-c_reg[k]) : c_reg[k];
            top = top | mg[k];
        end
        sh = 0;
        for (int k = 31; k < DotWidth; k++) if (top[k]) sh = k - 30;
        for (int k = 0; k < 4; k++) begin
            q_next[k] = q_t'(mg[k] >> sh);
            if (c_reg[k][DotWidth-1]) q_next[k] = -q_next[k];
        end
    end
    q_t q_reg [4];
    logic [SqWidth-1:0] sq_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) q_reg[k] <= q_next[k];
        end
    end
    // stage 5: sum of squares
    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= SqWidth'(q_reg[0] * q_reg[0]) + SqWidth'(q_reg[1] * q_reg[1])
                    + SqWidth'(q_reg[2] * q_reg[2]);
        end
    end
    // dot product delayed alongside the square root
    q_t d_dly_reg [SqLat+1];
    always_ff @(posedge aclk) begin
        if (en) begin
            d_dly_reg[0] <= q_reg[3];
            for (int k = 1; k <= SqLat; k++) d_dly_reg[k] <= d_dly_reg[k-1];
        end
    end

    logic [QWidth-1:0] root;
    bapt_isqrt u_sqrt (.aclk(aclk), .en(en), .rad(sq_reg), .root(root));

    // cordic vectoring, one step per stage
    cx_t x_reg [CordicSteps+1], y_reg [CordicSteps+1];
    acc_t z_reg [CordicSteps+1];
    always_ff @(posedge aclk) begin
        if (en) begin
            if (d_dly_reg[SqLat] < 0) begin
                x_reg[0] <= cx_t'(root);
                y_reg[0] <= -cx_t'(d_dly_reg[SqLat]);
                z_reg[0] <= HalfPiQ30;
            end else begin
                x_reg[0] <= cx_t'(d_dly_reg[SqLat]);
                y_reg[0] <= cx_t'(root);
                z_reg[0] <= '0;
            end
        end
    end
    for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!y_reg[i][CxWidth-1]) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_tab(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_tab(i);
                end
            end
        end
    end

    // clamp and round
    acc_t zc;
    logic [AccWidth-1:0] rnd;
    always_comb begin
        zc = z_reg[CordicSteps];
        if (zc < 0) zc = '0;
        if (zc > $signed(PiQ30)) zc = $signed(PiQ30);
        rnd = (AccWidth'(zc) + (AccWidth'(1) << (AccFrac - AngleFracBits - 1)))
              >> (AccFrac - AngleFracBits);
    end

    // valid and degenerate flags follow the data
    logic dg_in;
    assign dg_in = (u0 == 0 && u1 == 0 && u2 == 0) || (w0 == 0 && w1 == 0 && w2 == 0);
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[Lat-1:0], s_tvalid};
        end
        if (en) begin
            dg_reg <= {dg_reg[Lat-1:0], dg_in};
        end
    end

    // output register
    logic [15:0] out_reg;
    logic out_dg_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= dg_reg[Lat-1] ? '0 : rnd[AngleWidth-1:0];
            out_dg_reg <= dg_reg[Lat-1];
        end
    end
    assign m_tvalid = vld_reg[Lat];
    assign m_tdata = out_reg;
    assign m_tuser = out_dg_reg;
    logic unused_ok;
    assign unused_ok = dg_reg[Lat];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed in stall");
    a_deg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 0) else $error("degenerate angle not zero");
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata <= 16'd51472) else $error("angle above pi");
endmodule
